// ===== design/pli_pkg.sv =====
// ----------------------------------------------------------------------------
// pli_pkg
// Shared types and constants of the positional list insert block.
// ----------------------------------------------------------------------------
package pli_pkg;

  localparam int unsigned POS_W     = 7;
  localparam int unsigned PAYLOAD_W = 32;
  localparam int unsigned STATUS_W  = 2;
  // stream words, padded to whole bytes
  localparam int unsigned S_TDATA_W = 40;
  localparam int unsigned M_TDATA_W = 40;

  typedef enum logic {
    FUNC_INSERT = 1'b0,
    FUNC_DRAIN  = 1'b1
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK      = 2'd0,
    STATUS_BAD_POS = 2'd1,
    STATUS_FULL    = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_SPLICE,
    ST_LINK,
    ST_RESP,
    ST_DRAIN_STEP,
    ST_DRAIN_OUT
  } state_e;

endpackage

// ===== design/pli_ram.sv =====
// ----------------------------------------------------------------------------
// pli_ram
// Single write port, single read port memory with registered read data.
// ----------------------------------------------------------------------------
module pli_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== design/positional_list_insert.sv =====
// ----------------------------------------------------------------------------
// positional_list_insert
// Ordered list of up to CAPACITY entries kept as a linked list in memory;
// inserts an entry at a 1-based position or drains the list in order.
// ----------------------------------------------------------------------------
//
//  channel   dir  tdata (low bit up)              tuser        tlast
//  s_axis    in   position[6:0], payload[38:7]    func         -
//  m_axis    out  status[1:0], item_value[33:2]   item_valid   last
//
//  An insert walks to its slot, splices, links and waits for the status word;
//  the link walk follows one link per cycle through the link memory's read
//  port. A rejected insert or a drain of an empty list goes straight to the
//  status word. A drain reads each entry's link and payload, then sends the word.
//  Reset empties the list at once; no clearing pass is needed.
//  s_axis_tready is high only while idle; a stalled m_axis holds the word.
// ----------------------------------------------------------------------------
module positional_list_insert #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [pli_pkg::S_TDATA_W-1:0]  s_axis_tdata,  // position, payload
  input  logic                           s_axis_tuser,  // func
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [pli_pkg::M_TDATA_W-1:0]  m_axis_tdata,  // status, item_value
  output logic                           m_axis_tuser,  // item_valid
  output logic                           m_axis_tlast   // last
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);  // node index / count
  localparam int unsigned AW = $clog2(CAPACITY);      // memory address
  localparam int unsigned PW = pli_pkg::POS_W;
  localparam int unsigned DW = pli_pkg::PAYLOAD_W;

  pli_pkg::state_e  state_q, state_d;
  pli_pkg::status_e status_q, status_d;
  logic [CW-1:0]    count_q, count_d;
  logic [CW-1:0]    head_q, head_d;
  logic [CW-1:0]    pred_q, pred_d;
  logic [CW-1:0]    steps_q, steps_d;

  logic [PW-1:0]    in_pos;
  logic [DW-1:0]    in_payload;
  logic             s_hs, m_hs;
  logic [PW:0]      pos_ext, limit_ext;
  logic             full, pos_ok;
  logic [CW-1:0]    lnk, node;

  logic             link_wr_en, link_rd_en, pay_wr_en, pay_rd_en;
  logic [AW-1:0]    link_wr_addr, link_rd_addr;
  logic [CW-1:0]    link_wr_data, link_rd_data;
  logic [DW-1:0]    pay_rd_data;

  assign in_pos     = s_axis_tdata[PW-1:0];
  assign in_payload = s_axis_tdata[PW+DW-1:PW];
  assign s_hs       = s_axis_tvalid && s_axis_tready;
  assign m_hs       = m_axis_tvalid && m_axis_tready;

  assign pos_ext   = {1'b0, in_pos};
  assign limit_ext = (PW+1)'(count_q) + (PW+1)'(1);
  assign full      = (count_q == CW'(CAPACITY));
  assign pos_ok    = (in_pos != '0) && (pos_ext <= limit_ext);

  // the sentinel's link lives in a register, all others in the link memory
  assign lnk  = (pred_q == '0) ? head_q : link_rd_data;
  assign node = count_q + CW'(1);

  assign link_rd_addr = AW'(lnk - CW'(1));

  pli_ram #(.DEPTH(CAPACITY), .WIDTH(CW)) u_link_ram (
    .clk_i     (clk_i),
    .wr_en_i   (link_wr_en),
    .wr_addr_i (link_wr_addr),
    .wr_data_i (link_wr_data),
    .rd_en_i   (link_rd_en),
    .rd_addr_i (link_rd_addr),
    .rd_data_o (link_rd_data)
  );

  pli_ram #(.DEPTH(CAPACITY), .WIDTH(DW)) u_pay_ram (
    .clk_i     (clk_i),
    .wr_en_i   (pay_wr_en),
    .wr_addr_i (AW'(count_q)),
    .wr_data_i (in_payload),
    .rd_en_i   (pay_rd_en),
    .rd_addr_i (link_rd_addr),
    .rd_data_o (pay_rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pli_pkg::ST_IDLE;
      count_q <= '0;
      head_q  <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      head_q  <= head_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    pred_q   <= pred_d;
    steps_q  <= steps_d;
  end

  always_comb begin
    state_d      = state_q;
    status_d     = status_q;
    count_d      = count_q;
    head_d       = head_q;
    pred_d       = pred_q;
    steps_d      = steps_q;
    link_wr_en   = 1'b0;
    link_wr_addr = AW'(count_q);
    link_wr_data = lnk;
    link_rd_en   = 1'b0;
    pay_wr_en    = 1'b0;
    pay_rd_en    = 1'b0;
    case (state_q)
      pli_pkg::ST_IDLE: begin
        pred_d = '0;
        if (s_hs) begin
          if (s_axis_tuser == pli_pkg::FUNC_DRAIN) begin
            steps_d  = count_q;  // entries left to emit
            status_d = pli_pkg::STATUS_OK;
            state_d  = (count_q == '0) ? pli_pkg::ST_RESP : pli_pkg::ST_DRAIN_STEP;
          end else if (full) begin
            status_d = pli_pkg::STATUS_FULL;
            state_d  = pli_pkg::ST_RESP;
          end else if (!pos_ok) begin
            status_d = pli_pkg::STATUS_BAD_POS;
            state_d  = pli_pkg::ST_RESP;
          end else begin
            pay_wr_en = 1'b1;
            steps_d   = CW'(in_pos - PW'(1));
            state_d   = pli_pkg::ST_WALK;
          end
        end
      end
      pli_pkg::ST_WALK: begin
        if (steps_q == '0) begin
          state_d = pli_pkg::ST_SPLICE;
        end else begin
          pred_d     = lnk;
          link_rd_en = 1'b1;
          steps_d    = steps_q - CW'(1);
        end
      end
      pli_pkg::ST_SPLICE: begin
        // new node points at the successor of pred
        link_wr_en   = 1'b1;
        link_wr_addr = AW'(count_q);
        link_wr_data = lnk;
        state_d      = pli_pkg::ST_LINK;
      end
      pli_pkg::ST_LINK: begin
        if (pred_q == '0) begin
          head_d = node;
        end else begin
          link_wr_en   = 1'b1;
          link_wr_addr = AW'(pred_q - CW'(1));
          link_wr_data = node;
        end
        count_d  = node;
        status_d = pli_pkg::STATUS_OK;
        state_d  = pli_pkg::ST_RESP;
      end
      pli_pkg::ST_RESP: begin
        if (m_hs) begin
          state_d = pli_pkg::ST_IDLE;
        end
      end
      pli_pkg::ST_DRAIN_STEP: begin
        pred_d     = lnk;
        link_rd_en = 1'b1;
        pay_rd_en  = 1'b1;
        state_d    = pli_pkg::ST_DRAIN_OUT;
      end
      pli_pkg::ST_DRAIN_OUT: begin
        if (m_hs) begin
          if (steps_q == CW'(1)) begin
            head_d  = '0;
            count_d = '0;
            state_d = pli_pkg::ST_IDLE;
          end else begin
            steps_d = steps_q - CW'(1);
            state_d = pli_pkg::ST_DRAIN_STEP;
          end
        end
      end
      default: begin
        state_d = pli_pkg::ST_IDLE;
      end
    endcase
  end

  logic             out_item;
  logic [DW-1:0]    out_value;
  pli_pkg::status_e out_status;

  assign out_item   = (state_q == pli_pkg::ST_DRAIN_OUT);
  assign out_value  = out_item ? pay_rd_data : '0;
  assign out_status = out_item ? pli_pkg::STATUS_OK : status_q;

  assign s_axis_tready = (state_q == pli_pkg::ST_IDLE);
  assign m_axis_tvalid = (state_q == pli_pkg::ST_RESP) || out_item;
  assign m_axis_tdata  = {(pli_pkg::M_TDATA_W - DW - pli_pkg::STATUS_W)'(0),
                          out_value, out_status};
  assign m_axis_tuser  = out_item;
  assign m_axis_tlast  = out_item ? (steps_q == CW'(1)) : 1'b1;

  // one item in flight: never ready while a word is offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !m_axis_tvalid)
    else $error("input accepted while a result is pending");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("entry count above capacity");

  // the final drained word leaves an empty list
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_hs && out_item && m_axis_tlast) |=> (count_q == '0) && (head_q == '0))
    else $error("list not empty after drain");

  // a successful insert grows the list by one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pli_pkg::ST_LINK) |=> (count_q == $past(count_q) + CW'(1)))
    else $error("insert did not grow the list");

endmodule

// ===== test/positional_list_insert_checker.sv =====
// ----------------------------------------------------------------------------
// positional_list_insert_checker
// Watches both stream channels of the positional list insert block, keeps its
// own ordered copy of the list, predicts the status and drain words of every
// accepted input word, and compares each output word field by field against
// the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module positional_list_insert_checker #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  input  logic                            s_axis_tready,
  input  logic [pli_pkg::S_TDATA_W-1:0]   s_axis_tdata,   // position, payload
  input  logic                            s_axis_tuser,   // func
  input  logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  input  logic [pli_pkg::M_TDATA_W-1:0]   m_axis_tdata,   // status, item_value
  input  logic                            m_axis_tuser,   // item_valid
  input  logic                            m_axis_tlast,   // last
  output int unsigned                     fail_count_o,
  output int unsigned                     pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned POS_W     = pli_pkg::POS_W;
  localparam int unsigned PAYLOAD_W = pli_pkg::PAYLOAD_W;
  localparam int unsigned STATUS_W  = pli_pkg::STATUS_W;

  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic                 item_valid;
    logic [PAYLOAD_W-1:0] item_value;
    logic                 last;
  } list_word_t;

  logic [PAYLOAD_W-1:0] list_entries[$];   // payloads in list order
  list_word_t           due_words[$];
  int unsigned          fails;

  function automatic list_word_t make_word(pli_pkg::status_e st, logic valid,
                                           logic [PAYLOAD_W-1:0] value, logic last);
    list_word_t w;
    w.status     = st;
    w.item_valid = valid;
    w.item_value = value;
    w.last       = last;
    return w;
  endfunction

  function automatic void predict_list_op(pli_pkg::func_e func, logic [POS_W-1:0] pos,
                                          logic [PAYLOAD_W-1:0] payload);
    int unsigned n;
    n = list_entries.size();
    if (func == pli_pkg::FUNC_INSERT) begin
      if (n >= CAPACITY) begin
        due_words.push_back(make_word(pli_pkg::STATUS_FULL, 1'b0, '0, 1'b1));
      end else if (pos == '0 || int'(pos) > n + 1) begin
        due_words.push_back(make_word(pli_pkg::STATUS_BAD_POS, 1'b0, '0, 1'b1));
      end else begin
        // new entry lands at 1-based position pos
        list_entries.insert(int'(pos) - 1, payload);
        due_words.push_back(make_word(pli_pkg::STATUS_OK, 1'b0, '0, 1'b1));
      end
    end else begin
      if (n == 0) begin
        due_words.push_back(make_word(pli_pkg::STATUS_OK, 1'b0, '0, 1'b1));
      end else begin
        foreach (list_entries[i]) begin
          due_words.push_back(make_word(pli_pkg::STATUS_OK, 1'b1, list_entries[i],
                                        i == n - 1));
        end
      end
      list_entries.delete();
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    list_word_t got;
    list_word_t want;
    if (!rst_ni) begin
      list_entries.delete();
      due_words.delete();
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_list_op(pli_pkg::func_e'(s_axis_tuser), s_axis_tdata[POS_W-1:0],
                        s_axis_tdata[POS_W +: PAYLOAD_W]);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.status     = m_axis_tdata[STATUS_W-1:0];
        got.item_valid = m_axis_tuser;
        got.item_value = m_axis_tdata[STATUS_W +: PAYLOAD_W];
        got.last       = m_axis_tlast;
        if (due_words.size() == 0) begin
          fails++;
          if (fails <= 10) begin
            $display("%t unexpected word: status %0d valid %0b value %08h last %0b",
                     $realtime, got.status, got.item_valid, got.item_value, got.last);
          end
        end else begin
          want = due_words.pop_front();
          if (got.status !== want.status || got.item_valid !== want.item_valid ||
              got.item_value !== want.item_value || got.last !== want.last) begin
            fails++;
            if (fails <= 10) begin
              $display("%t word mismatch: expected status %0d valid %0b value %08h last %0b",
                       $realtime, want.status, want.item_valid, want.item_value, want.last);
              $display("%t                got      status %0d valid %0b value %08h last %0b",
                       $realtime, got.status, got.item_valid, got.item_value, got.last);
            end
          end
        end
      end
    end
    fail_count_o <= fails;
    pending_o    <= due_words.size();
  end

endmodule

// ===== test/positional_list_insert_tb.sv =====
// ----------------------------------------------------------------------------
// positional_list_insert_tb
// Drives insert and drain words into the positional list insert block: a
// directed run over the edge cases, then fill-and-drain sequences with random
// positions and payloads, mixed with bad positions, inserts into a full list
// and early drains. Sender gaps and receiver stalls change by phase, and one
// long output hold backs the block up. The checker predicts and compares.
// ----------------------------------------------------------------------------
module positional_list_insert_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CAPACITY    = 64;
  localparam int unsigned ITEM_BUDGET = 230;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned POS_W       = pli_pkg::POS_W;
  localparam int unsigned PAYLOAD_W   = pli_pkg::PAYLOAD_W;

  logic                           clk_i;
  logic                           rst_ni;
  logic                           s_axis_tvalid;
  logic                           s_axis_tready;
  logic [pli_pkg::S_TDATA_W-1:0]  s_axis_tdata;   // position, payload
  logic                           s_axis_tuser;   // func
  logic                           m_axis_tvalid;
  logic                           m_axis_tready;
  logic [pli_pkg::M_TDATA_W-1:0]  m_axis_tdata;   // status, item_value
  logic                           m_axis_tuser;   // item_valid
  logic                           m_axis_tlast;   // last

  int unsigned fail_count;
  int unsigned pending_words;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned hold_req;
  int unsigned hold_done;
  int unsigned list_len;
  int unsigned words_sent;

  positional_list_insert #(
    .CAPACITY (CAPACITY)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  positional_list_insert_checker #(
    .CAPACITY (CAPACITY)
  ) checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .fail_count_o  (fail_count),
    .pending_o     (pending_words)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5ms;
    $display("positional_list_insert_tb NOT OK");
    $finish;
  end

  // output side: random stalls, or one long hold when asked
  initial begin
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req != hold_done) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_done <= hold_done + 1;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic set_pace(int unsigned send_pct, int unsigned recv_pct);
    send_idle_pct = send_pct;
    recv_stall_pct <= recv_pct;
  endtask

  task automatic send_word(pli_pkg::func_e func, logic [POS_W-1:0] pos,
                           logic [PAYLOAD_W-1:0] payload);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, payload, pos};
    s_axis_tuser  <= func;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    words_sent++;
    // track the length only to steer positions into range
    if (func == pli_pkg::FUNC_DRAIN) begin
      list_len = 0;
    end else if (list_len < CAPACITY && pos != '0 && int'(pos) <= list_len + 1) begin
      list_len++;
    end
  endtask

  initial begin
    int unsigned episode;
    int unsigned target;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= pli_pkg::FUNC_INSERT;
    set_pace(0, 0);
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty drain, bad positions, head, middle and tail inserts
    send_word(pli_pkg::FUNC_DRAIN, 7'd0, 32'h0);
    send_word(pli_pkg::FUNC_INSERT, 7'd0, 32'h0);
    send_word(pli_pkg::FUNC_INSERT, 7'd2, 32'h1234_5678);
    send_word(pli_pkg::FUNC_INSERT, 7'd64, 32'hFFFF_FFFF);
    send_word(pli_pkg::FUNC_INSERT, 7'd1, 32'hFFFF_FFFF);
    send_word(pli_pkg::FUNC_INSERT, 7'd1, 32'h0000_0000);
    send_word(pli_pkg::FUNC_INSERT, 7'd3, 32'hA5A5_5A5A);
    send_word(pli_pkg::FUNC_INSERT, 7'd2, 32'h0000_0001);
    send_word(pli_pkg::FUNC_INSERT, 7'd6, 32'hDEAD_BEEF);
    send_word(pli_pkg::FUNC_INSERT, 7'd5, 32'h8000_0000);
    send_word(pli_pkg::FUNC_INSERT, 7'd63, $urandom);
    send_word(pli_pkg::FUNC_DRAIN, 7'd64, 32'hFFFF_FFFF);
    send_word(pli_pkg::FUNC_DRAIN, 7'd0, 32'h0);
    send_word(pli_pkg::FUNC_INSERT, 7'd1, $urandom);
    send_word(pli_pkg::FUNC_DRAIN, 7'd1, $urandom);
    send_word(pli_pkg::FUNC_INSERT, 7'd1, $urandom);
    send_word(pli_pkg::FUNC_INSERT, 7'd2, $urandom);
    send_word(pli_pkg::FUNC_INSERT, 7'd1, $urandom);
    send_word(pli_pkg::FUNC_DRAIN, 7'd0, 32'h0);

    // random fill-and-drain sequences
    episode = 0;
    while (words_sent < ITEM_BUDGET) begin
      case (episode % 4)
        0: set_pace(0, 0);
        1: set_pace(72, 0);
        2: set_pace(0, 72);
        default: set_pace(27, 27);
      endcase
      // long output hold while the input keeps offering
      if (episode == 4) hold_req <= hold_req + 1;
      if (episode == 0 || (words_sent + 80 < ITEM_BUDGET && $urandom_range(7) == 0)) begin
        target = CAPACITY;
      end else begin
        target = $urandom_range(1, 12);
      end
      while (list_len < target) begin
        if ($urandom_range(7) == 0) begin
          send_word(pli_pkg::FUNC_INSERT, POS_W'($urandom_range(0, 64)), $urandom);
        end else if (target < CAPACITY && $urandom_range(15) == 0) begin
          send_word(pli_pkg::FUNC_DRAIN, POS_W'($urandom_range(0, 64)), $urandom);
        end else begin
          send_word(pli_pkg::FUNC_INSERT, POS_W'($urandom_range(1, list_len + 1)),
                    $urandom);
        end
      end
      if (list_len == CAPACITY) begin
        send_word(pli_pkg::FUNC_INSERT, 7'd64, $urandom);
        repeat ($urandom_range(1, 3)) begin
          send_word(pli_pkg::FUNC_INSERT, POS_W'($urandom_range(0, 64)), $urandom);
        end
      end
      send_word(pli_pkg::FUNC_DRAIN, POS_W'($urandom_range(0, 64)), $urandom);
      episode++;
    end

    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_words != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (fail_count == 0 && pending_words == 0) begin
      $display("positional_list_insert_tb OK");
    end else begin
      $display("positional_list_insert_tb NOT OK");
    end
    $finish;
  end

endmodule

// ===== positional_list_insert.f =====
design/pli_pkg.sv
design/pli_ram.sv
design/positional_list_insert.sv
test/positional_list_insert_checker.sv
test/positional_list_insert_tb.sv
